// ===== sv/cse_pkg.sv =====
// ----------------------------------------------------------------------------
// cse_pkg: shared types and constants for the cosine similarity engine
// Widths of the running sums, the shared arithmetic unit and the result,
// the sequencer state encoding and the request/response bundles of the ALU.
// ----------------------------------------------------------------------------
package cse_pkg;

  localparam int ELEM_W    = 16;  // element port width
  localparam int PROD_W    = 32;  // element product width
  localparam int SUM_W     = 48;  // running sum width
  localparam int ADD_W     = 51;  // shared adder width
  localparam int REM_W     = 49;  // root / division remainder width
  localparam int WIDE_W    = 96;  // product of the two magnitudes
  localparam int DIVD_W    = 64;  // dividend and quotient width
  localparam int FRAC_BITS = 16;  // Q1.16 fraction bits
  localparam int COS_W     = 17;  // result width
  localparam int CNT_W     = 6;   // iteration counter width

  localparam logic [SUM_W-1:0] SUM_MAX       = {SUM_W{1'b1}};
  localparam logic [COS_W-1:0] ONE_Q16       = 17'h10000;
  localparam logic [CNT_W-1:0] MUL_STEPS_M1  = 6'd47;
  localparam logic [CNT_W-1:0] ROOT_STEPS_M1 = 6'd47;
  localparam logic [CNT_W-1:0] DIV_STEPS_M1  = 6'd63;

  // Product selection in the accumulate phase
  localparam logic [1:0] IDX_AA = 2'd0;
  localparam logic [1:0] IDX_BB = 2'd1;
  localparam logic [1:0] IDX_AB = 2'd2;
  localparam logic [1:0] IDX_LAST = 2'd3;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_ACC  = 7'b0000010,
    S_CHK  = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_SQRT = 7'b0010000,
    S_DIV  = 7'b0100000,
    S_FIN  = 7'b1000000
  } state_t;

  typedef struct packed {
    logic              sub;
    logic [ADD_W-1:0]  op_a;
    logic [ADD_W-1:0]  op_b;
    logic [ELEM_W-1:0] mul_a;
    logic [ELEM_W-1:0] mul_b;
  } alu_req_t;

  typedef struct packed {
    logic [ADD_W-1:0]  sum;
    logic              carry;
    logic [PROD_W-1:0] prod;
  } alu_rsp_t;

endpackage

// ===== sv/cse_alu.sv =====
// ----------------------------------------------------------------------------
// cse_alu: shared arithmetic unit
// One 16x16 multiplier and one 51-bit adder/subtractor with carry out.
// On subtract the carry out is high when op_a >= op_b (no borrow).
// ----------------------------------------------------------------------------
module cse_alu (
  input  cse_pkg::alu_req_t req,
  output cse_pkg::alu_rsp_t rsp
);
  import cse_pkg::*;

  logic [ADD_W:0]   total;
  logic [ADD_W-1:0] op_b_eff;

  // two's complement subtract: a + ~b + 1
  assign op_b_eff = req.sub ? ~req.op_b : req.op_b;
  assign total    = {1'b0, req.op_a} + {1'b0, op_b_eff} + {{ADD_W{1'b0}}, req.sub};

  assign rsp.sum   = total[ADD_W-1:0];
  assign rsp.carry = total[ADD_W];
  assign rsp.prod  = req.mul_a * req.mul_b;

endmodule

// ===== sv/cosine_similarity_engine.sv =====
// ----------------------------------------------------------------------------
// cosine_similarity_engine: streaming integer cosine similarity
// Accumulates dot product and squared magnitudes of two count vectors and,
// on the final pair, returns min(1.0, dot / floor(sqrt(|a|^2 * |b|^2))) in
// unsigned Q1.16, or zero with the degenerate flag when a magnitude is zero.
// ----------------------------------------------------------------------------
// Each element pair is accepted in the idle state and then passes through the
// shared 16x16 multiplier and 51-bit adder (three products, three saturating
// adds). A final pair then runs a check, a shift-add multiply, a square root
// and a restoring divide, all on the same adder, and loads the result register
// once the output slot is free; when a magnitude is zero the check goes straight
// to loading the result. The result sits in an output register, so a new pair
// is taken while the last result waits.
module cosine_similarity_engine #(
  parameter int ELEM_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [cse_pkg::ELEM_W-1:0]  elem_a,
  input  logic [cse_pkg::ELEM_W-1:0]  elem_b,
  input  logic                        last_pair,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [cse_pkg::COS_W-1:0]   cosine_q16,
  output logic                        degenerate
);
  import cse_pkg::*;

  localparam int EFF_BITS = (ELEM_BITS < ELEM_W) ? ELEM_BITS : ELEM_W;
  localparam logic [ELEM_W-1:0] ELEM_MASK = {ELEM_W{1'b1}} >> (ELEM_W - EFF_BITS);

  state_t            state, state_next;
  logic [1:0]        idx;
  logic [CNT_W-1:0]  step;
  logic [ELEM_W-1:0] a_reg, b_reg;
  logic              last_reg;
  logic              degen_reg;
  logic [PROD_W-1:0] prod;
  logic [SUM_W-1:0]  dot_sum, mag_a_sum, mag_b_sum;
  logic [WIDE_W-1:0] acc;
  logic [REM_W-1:0]  rem;
  logic [SUM_W-1:0]  root;

  alu_req_t          req;
  alu_rsp_t          rsp;
  logic              slot_free;
  logic [SUM_W-1:0]  sat_sum;
  logic [DIVD_W-1:0] quot;
  logic              over_one;
  logic [COS_W-1:0]  cos_clamped;

  cse_alu u_alu (
    .req (req),
    .rsp (rsp)
  );

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;

  // saturating result of an accumulate add
  assign sat_sum = rsp.sum[SUM_W] ? SUM_MAX : rsp.sum[SUM_W-1:0];

  // clamp quotient to 1.0
  assign quot        = acc[DIVD_W-1:0];
  assign over_one    = (|quot[DIVD_W-1:COS_W]) || (quot[FRAC_BITS] && (|quot[FRAC_BITS-1:0]));
  assign cos_clamped = over_one ? ONE_Q16 : quot[COS_W-1:0];

  // operand steering for the shared unit
  always_comb begin
    req = '0;
    case (idx)
      IDX_AA: begin
        req.mul_a = a_reg;
        req.mul_b = a_reg;
      end
      IDX_BB: begin
        req.mul_a = b_reg;
        req.mul_b = b_reg;
      end
      default: begin
        req.mul_a = a_reg;
        req.mul_b = b_reg;
      end
    endcase
    case (state)
      S_ACC: begin
        req.sub  = 1'b0;
        req.op_b = {{(ADD_W-PROD_W){1'b0}}, prod};
        case (idx)
          IDX_BB:  req.op_a = {{(ADD_W-SUM_W){1'b0}}, mag_a_sum};
          IDX_AB:  req.op_a = {{(ADD_W-SUM_W){1'b0}}, mag_b_sum};
          default: req.op_a = {{(ADD_W-SUM_W){1'b0}}, dot_sum};
        endcase
      end
      S_MUL: begin
        req.sub  = 1'b0;
        req.op_a = {{(ADD_W-SUM_W){1'b0}}, acc[WIDE_W-1:SUM_W]};
        req.op_b = acc[0] ? {{(ADD_W-SUM_W){1'b0}}, mag_a_sum} : '0;
      end
      S_SQRT: begin
        req.sub  = 1'b1;
        req.op_a = {rem, acc[WIDE_W-1:WIDE_W-2]};
        req.op_b = {1'b0, root, 2'b01};
      end
      S_DIV: begin
        req.sub  = 1'b1;
        req.op_a = {{(ADD_W-REM_W){1'b0}}, rem[REM_W-2:0], acc[DIVD_W-1]};
        req.op_b = {{(ADD_W-SUM_W){1'b0}}, root};
      end
      default: begin
        req.sub  = 1'b0;
        req.op_a = '0;
        req.op_b = '0;
      end
    endcase
  end

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (in_valid) state_next = S_ACC;
      S_ACC: begin
        if (idx == IDX_LAST) state_next = last_reg ? S_CHK : S_IDLE;
      end
      S_CHK: begin
        if (mag_a_sum == '0 || mag_b_sum == '0) state_next = S_FIN;
        else state_next = S_MUL;
      end
      S_MUL:  if (step == '0) state_next = S_SQRT;
      S_SQRT: if (step == '0) state_next = S_DIV;
      S_DIV:  if (step == '0) state_next = S_FIN;
      S_FIN:  if (slot_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_FIN && slot_free) out_valid <= 1'b1;
      else if (out_ready)              out_valid <= 1'b0;
    end
  end

  // running sums: cleared by reset and after each result
  always_ff @(posedge clk) begin
    if (rst) begin
      dot_sum   <= '0;
      mag_a_sum <= '0;
      mag_b_sum <= '0;
    end else if (state == S_FIN && slot_free) begin
      dot_sum   <= '0;
      mag_a_sum <= '0;
      mag_b_sum <= '0;
    end else if (state == S_ACC) begin
      case (idx)
        IDX_BB:   mag_a_sum <= sat_sum;
        IDX_AB:   mag_b_sum <= sat_sum;
        IDX_LAST: dot_sum   <= sat_sum;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        a_reg    <= elem_a & ELEM_MASK;
        b_reg    <= elem_b & ELEM_MASK;
        last_reg <= last_pair;
        idx      <= IDX_AA;
      end
      S_ACC: begin
        prod <= rsp.prod;
        idx  <= idx + 2'd1;
      end
      S_CHK: begin
        degen_reg <= (mag_a_sum == '0) || (mag_b_sum == '0);
        acc       <= {{(WIDE_W-SUM_W){1'b0}}, mag_b_sum};
        step      <= MUL_STEPS_M1;
      end
      // shift-add multiply: magnitude product into acc
      S_MUL: begin
        acc <= {rsp.sum[SUM_W:0], acc[SUM_W-1:1]};
        if (step == '0) begin
          rem  <= '0;
          root <= '0;
          step <= ROOT_STEPS_M1;
        end else begin
          step <= step - 1'b1;
        end
      end
      // digit-by-digit square root, two radicand bits a step
      S_SQRT: begin
        root <= {root[SUM_W-2:0], rsp.carry};
        if (step == '0) begin
          acc  <= {{(WIDE_W-SUM_W-FRAC_BITS){1'b0}}, dot_sum, {FRAC_BITS{1'b0}}};
          rem  <= '0;
          step <= DIV_STEPS_M1;
        end else begin
          acc  <= {acc[WIDE_W-3:0], 2'b00};
          step <= step - 1'b1;
          if (rsp.carry) rem <= rsp.sum[REM_W-1:0];
          else           rem <= {rem[REM_W-3:0], acc[WIDE_W-1:WIDE_W-2]};
        end
      end
      // restoring divide, quotient bits shift in at the bottom
      S_DIV: begin
        if (rsp.carry) rem <= rsp.sum[REM_W-1:0];
        else           rem <= {rem[REM_W-2:0], acc[DIVD_W-1]};
        acc[DIVD_W-1:0] <= {acc[DIVD_W-2:0], rsp.carry};
        step <= step - 1'b1;
      end
      S_FIN: begin
        if (slot_free) begin
          degenerate <= degen_reg;
          cosine_q16 <= degen_reg ? '0 : cos_clamped;
        end
      end
      default: ;
    endcase
  end

  // checks
  a_sums_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && slot_free) |=>
      (dot_sum == '0 && mag_a_sum == '0 && mag_b_sum == '0))
    else $error("running sums not cleared after a result");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && degenerate) |-> (cosine_q16 == '0))
    else $error("degenerate result with non-zero cosine");

  a_cos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (cosine_q16 <= ONE_Q16))
    else $error("cosine above 1.0");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem[REM_W-2:0] < root && !rem[REM_W-1]))
    else $error("division remainder not below divisor");

endmodule

// ===== sim/cosine_similarity_engine_tb.sv =====
// ----------------------------------------------------------------------------
// cosine_similarity_engine_tb: self-checking bench for the similarity engine
// Streams element pairs through the input channel, folds every accepted beat
// into a bit-exact integer model of the three running sums, and on each final
// pair predicts the Q1.16 cosine and degenerate flag. Output beats are checked
// in order against the predictions. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module cosine_similarity_engine_tb;

  import cse_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int RANDOM_PAIRS = 700;
  localparam int SETTLE       = 200;    // idle margin after the last result

  typedef struct {
    logic [ELEM_W-1:0] a;
    logic [ELEM_W-1:0] b;
    logic              fin;
    int unsigned       gap;
    bit                wait_drain;
  } pair_t;

  typedef struct {
    logic [COS_W-1:0] cosine;
    logic             degen;
  } similarity_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [ELEM_W-1:0] elem_a = '0;
  logic [ELEM_W-1:0] elem_b = '0;
  logic              last_pair = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [COS_W-1:0]  cosine_q16;
  logic              degenerate;

  // pending input beats, predicted results
  pair_t       pair_queue[$];
  similarity_t similarity_q[$];

  // model copy of the running sums
  logic [SUM_W-1:0] dot_acc, mag_a_acc, mag_b_acc;

  pair_t       cur_pair;
  bit          pair_loaded;
  int unsigned gap_left;
  int unsigned hold_left;
  int unsigned calm_left;
  int          random_count;
  int          mismatches;
  int          cycle_count;
  logic        in_beat, out_beat;

  cosine_similarity_engine dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .elem_a     (elem_a),
    .elem_b     (elem_b),
    .last_pair  (last_pair),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cosine_q16 (cosine_q16),
    .degenerate (degenerate)
  );

  always #4 clk = ~clk;

  task automatic flag_mismatch(input string msg);
    if (mismatches < 100) $display("[%0d] mismatch: %s", cycle_count, msg);
    mismatches++;
  endtask

  function automatic logic [SUM_W-1:0] sat_add48(input logic [SUM_W-1:0] acc,
                                                 input logic [PROD_W-1:0] p);
    logic [SUM_W:0] t;
    t = {1'b0, acc} + {{(SUM_W+1-PROD_W){1'b0}}, p};
    return t[SUM_W] ? SUM_MAX : t[SUM_W-1:0];
  endfunction

  // Fold one accepted pair into the sums; on a final pair predict the result
  task automatic fold_pair(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b,
                           input logic fin);
    logic [95:0]      prod, trial;
    logic [SUM_W-1:0] root, c;
    logic [63:0]      quot;
    similarity_t      r;
    dot_acc   = sat_add48(dot_acc,   32'(a) * 32'(b));
    mag_a_acc = sat_add48(mag_a_acc, 32'(a) * 32'(a));
    mag_b_acc = sat_add48(mag_b_acc, 32'(b) * 32'(b));
    if (fin) begin
      r.cosine = '0;
      r.degen  = 1'b0;
      if (mag_a_acc == '0 || mag_b_acc == '0) begin
        r.degen = 1'b1;
      end else begin
        // exact floor(sqrt(|a|^2 * |b|^2)), one bit per step
        prod = 96'(mag_a_acc) * 96'(mag_b_acc);
        root = '0;
        for (int k = SUM_W - 1; k >= 0; k--) begin
          c     = root | (48'd1 << k);
          trial = 96'(c) * 96'(c);
          if (trial <= prod) root = c;
        end
        if (root == '0) root = 48'd1;
        quot     = {dot_acc, 16'h0000} / 64'(root);
        r.cosine = (quot > 64'(ONE_Q16)) ? ONE_Q16 : quot[COS_W-1:0];
      end
      similarity_q.insert(similarity_q.size(), r);
      dot_acc   = '0;
      mag_a_acc = '0;
      mag_b_acc = '0;
    end
  endtask

  task automatic add_pair(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b,
                          input logic fin, input bit wait_drain);
    pair_t p;
    p.a          = a;
    p.b          = b;
    p.fin        = fin;
    p.wait_drain = wait_drain;
    // stretches with no gaps between random gappy ones
    if (calm_left != 0) begin
      calm_left--;
      p.gap = 0;
    end else begin
      if ($urandom_range(0, 29) == 0) calm_left = $urandom_range(10, 40);
      p.gap = $urandom_range(0, 9);
    end
    pair_queue.insert(pair_queue.size(), p);
  endtask

  function automatic logic [ELEM_W-1:0] draw_elem(input int style);
    logic [ELEM_W-1:0] v;
    case (style)
      0: v = 16'($urandom);
      1: v = 16'($urandom_range(0, 15));
      2: begin
        case ($urandom_range(0, 3))
          0: v = 16'h0000;
          1: v = 16'h0001;
          2: v = 16'h8000;
          default: v = 16'hFFFF;
        endcase
      end
      default: v = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom);
    endcase
    return v;
  endfunction

  // One vector of random length and flavour, ending on a final pair
  task automatic queue_random_vector();
    int                len, style;
    bit                zero_a, zero_b, aligned;
    logic [ELEM_W-1:0] a, b;
    len     = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
    style   = $urandom_range(0, 3);
    zero_a  = ($urandom_range(0, 11) == 0);
    zero_b  = ($urandom_range(0, 11) == 0);
    aligned = ($urandom_range(0, 4) == 0);
    for (int i = 0; i < len; i++) begin
      a = zero_a ? 16'h0000 : draw_elem(style);
      if (aligned) b = zero_b ? 16'h0000 : (a >> $urandom_range(0, 3));
      else         b = zero_b ? 16'h0000 : draw_elem(style);
      add_pair(a, b, i == len - 1, 1'b0);
      random_count++;
    end
  endtask

  // Input side: one beat per queued pair, gaps drawn per pair
  always @(negedge clk) begin
    logic nv;
    if (rst) begin
      in_valid    <= 1'b0;
      pair_loaded  = 1'b0;
      gap_left     = 0;
    end else begin
      nv = in_valid;
      if (in_valid && in_beat) nv = 1'b0;
      if (!nv) begin
        if (!pair_loaded && pair_queue.size() != 0) begin
          cur_pair    = pair_queue.pop_front();
          pair_loaded = 1'b1;
          gap_left    = cur_pair.gap;
        end
        if (pair_loaded) begin
          if (gap_left != 0) begin
            gap_left--;
          end else if (!cur_pair.wait_drain || similarity_q.size() == 0) begin
            elem_a      <= cur_pair.a;
            elem_b      <= cur_pair.b;
            last_pair   <= cur_pair.fin;
            nv           = 1'b1;
            pair_loaded  = 1'b0;
          end
        end
      end
      in_valid <= nv;
    end
  end

  // Output side: ready held low for a drawn number of valid cycles per result
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left  = 0;
    end else begin
      if (out_beat)
        hold_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        if (out_valid) hold_left--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Monitor: check result beats, then fold accepted input beats
  always @(posedge clk) begin
    similarity_t exp_r;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else if (rst) begin
      in_beat   <= 1'b0;
      out_beat  <= 1'b0;
      dot_acc    = '0;
      mag_a_acc  = '0;
      mag_b_acc  = '0;
    end else begin
      in_beat  <= in_valid && in_ready;
      out_beat <= out_valid && out_ready;
      if (out_valid && out_ready) begin
        if (similarity_q.size() == 0) begin
          flag_mismatch($sformatf("unexpected result cos=%0d degen=%0b",
                                  cosine_q16, degenerate));
        end else begin
          exp_r = similarity_q.pop_front();
          if (cosine_q16 !== exp_r.cosine)
            flag_mismatch($sformatf("cosine_q16 got %0d want %0d",
                                    cosine_q16, exp_r.cosine));
          if (degenerate !== exp_r.degen)
            flag_mismatch($sformatf("degenerate got %0b want %0b",
                                    degenerate, exp_r.degen));
        end
      end
      if (in_valid && in_ready) fold_pair(elem_a, elem_b, last_pair);
    end
  end

  initial begin
    mismatches   = 0;
    cycle_count  = 0;
    calm_left    = 0;
    random_count = 0;

    // directed: zero vectors, single pairs, extremes, orthogonal vectors
    add_pair(16'h0000, 16'h0000, 1'b1, 1'b0);
    add_pair(16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
    add_pair(16'h0001, 16'hFFFF, 1'b1, 1'b0);
    add_pair(16'h0000, 16'h0005, 1'b1, 1'b0);
    add_pair(16'h0007, 16'h0000, 1'b0, 1'b0);
    add_pair(16'h0000, 16'h0000, 1'b1, 1'b0);
    add_pair(16'hFFFF, 16'h0000, 1'b0, 1'b0);
    add_pair(16'h0000, 16'hFFFF, 1'b1, 1'b0);
    add_pair(16'h0001, 16'hFFFF, 1'b0, 1'b0);
    add_pair(16'hFFFF, 16'h0001, 1'b1, 1'b0);
    add_pair(16'h5555, 16'hAAAA, 1'b0, 1'b0);
    add_pair(16'hAAAA, 16'h5555, 1'b0, 1'b0);
    add_pair(16'hFFFF, 16'h0001, 1'b1, 1'b0);
    add_pair(16'h8000, 16'h7FFF, 1'b1, 1'b0);

    // random vectors; the first waits for the pipeline to drain
    add_pair(16'($urandom), 16'($urandom), 1'b1, 1'b1);
    while (random_count < RANDOM_PAIRS) queue_random_vector();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (pair_queue.size() != 0 || pair_loaded || in_valid) @(posedge clk);
    while (similarity_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
